>>> rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
// Holds the request/result payload structs, action codes and character codes.
// No dependencies.
package tcw_pkg;

    localparam int CELL_W = 16;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  char_code;
        logic [10:0] cell_address;
    } req_t;

    typedef struct packed {
        logic [15:0] cell_data;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
    } rsp_t;

    localparam logic [1:0] ACT_PUT   = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_RETURN  = 8'd13;
    localparam logic [7:0] CH_SPACE   = 8'd32;

    // Register index, taken from paddr[2]
    localparam logic REG_FOREGROUND = 1'b0;
    localparam logic REG_BACKGROUND = 1'b1;

endpackage

>>> rtl/tcw_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/text_console_writer.sv
// Text console writer top level: cell memory, cursor, attribute registers, sweeps.
// Depends on tcw_pkg (payload types, codes) and tcw_ram (cell store).
//
// A SCREEN_ROWS x SCREEN_COLUMNS store of 16-bit cells (character in the low
// byte, attribute in the high byte) with a cursor, driven one transaction at a
// time. A put of an ordinary character or a control code that keeps the
// cursor on the screen has its result registered at the accepting edge; a
// read passes through ST_READ because the cell memory has a registered read.
// A put that runs the cursor past the last row scrolls through ST_PRIME and
// ST_SCROLL, one cell copied per cycle through the memory's single write
// port, the bottom row filled with blanks in the same sweep. A clear fills
// every cell with blanks in ST_FILL. After reset the block zeroes the store
// in ST_FILL with s_ready low; configuration writes are taken during that
// pass. Every transaction gives exactly one result holding the cursor after
// it; cell_data is nonzero only for a read. Change the colors only while the
// block is idle.
module text_console_writer #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25
) (
    input  logic          aclk,
    input  logic          aresetn,
    // request channel
    input  logic          s_valid,
    output logic          s_ready,
    input  tcw_pkg::req_t s_data,
    // result channel
    output logic          m_valid,
    input  logic          m_ready,
    output tcw_pkg::rsp_t m_data,
    // configuration port
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    import tcw_pkg::*;

    localparam int CELL_COUNT = SCREEN_ROWS * SCREEN_COLUMNS;
    localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    // pointer arithmetic that may step past the store
    localparam int PTR_W      = ADDR_W + 2;
    localparam int ROW_W      = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
    localparam int COL_W      = (SCREEN_COLUMNS > 1) ? $clog2(SCREEN_COLUMNS) : 1;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);
    localparam logic [PTR_W-1:0]  COLS_P    = PTR_W'(SCREEN_COLUMNS);
    localparam logic [PTR_W-1:0]  CELL_P    = PTR_W'(CELL_COUNT);
    localparam logic [PTR_W-1:0]  KEEP_P    = PTR_W'(CELL_COUNT - SCREEN_COLUMNS);
    localparam logic [ROW_W:0]    ROWS_R    = (ROW_W + 1)'(SCREEN_ROWS);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(SCREEN_ROWS - 1);
    localparam logic [COL_W:0]    COLS_C    = (COL_W + 1)'(SCREEN_COLUMNS);

    typedef enum logic [2:0] {
        ST_IDLE,    // take a transaction
        ST_READ,    // memory read in flight
        ST_PRIME,   // issue first read of the scroll copy
        ST_SCROLL,  // copy each row up one, blank the bottom row
        ST_FILL     // write one value to every cell (reset or clear)
    } state_t;

    state_t            state_reg, state_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [3:0]        fg_reg, bg_reg;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    logic [15:0]       fill_data_reg, fill_data_next;
    logic              fill_report_reg, fill_report_next;
    logic              read_hit_reg, read_hit_next;
    logic              m_valid_reg, m_valid_next;
    rsp_t              m_data_reg, m_data_next;

    // cell memory controls
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [15:0]       ram_wr_data;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [15:0]       ram_rd_data;

    logic              accept;
    logic [15:0]       blank_cell;
    logic [ADDR_W-1:0] cursor_addr;
    logic [ROW_W:0]    row_inc;
    logic [COL_W:0]    col_inc;
    logic [ROW_W:0]    put_row;
    logic [COL_W:0]    put_col;
    logic [PTR_W-1:0]  scroll_rd_ptr;
    logic              cfg_write;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_cells (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Hold off new transactions while a read, scroll or fill runs or a result cannot leave.
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign blank_cell  = {bg_reg, fg_reg, CH_SPACE};
    assign cursor_addr = ADDR_W'(PTR_W'(row_reg) * COLS_P + PTR_W'(col_reg));
    assign row_inc     = {1'b0, row_reg} + 1'b1;
    assign col_inc     = {1'b0, col_reg} + 1'b1;
    // Scroll copy reads the source of the next cell, one row and one cell past the cell being written.
    assign scroll_rd_ptr = PTR_W'(sweep_reg) + COLS_P + 1'b1;

    // Cursor motion of a put; row may land one past the last row.
    always_comb begin
        case (s_data.char_code)
            CH_NEWLINE: begin
                put_row = row_inc;
                put_col = '0;
            end
            CH_RETURN: begin
                put_row = {1'b0, row_reg};
                put_col = '0;
            end
            default: begin
                if (col_inc == COLS_C) begin
                    put_row = row_inc;
                    put_col = '0;
                end else begin
                    put_row = {1'b0, row_reg};
                    put_col = col_inc;
                end
            end
        endcase
    end

    always_comb begin
        state_next       = state_reg;
        row_next         = row_reg;
        col_next         = col_reg;
        sweep_next       = sweep_reg;
        fill_data_next   = fill_data_reg;
        fill_report_next = fill_report_reg;
        read_hit_next    = read_hit_reg;
        // drop the result once taken
        m_valid_next     = m_valid_reg && !m_ready;
        m_data_next      = m_data_reg;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = cursor_addr;
        ram_wr_data      = {bg_reg, fg_reg, s_data.char_code};
        ram_rd_en        = 1'b0;
        ram_rd_addr      = ADDR_W'(s_data.cell_address);

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_data.action)
                        ACT_PUT: begin
                            // Write every byte but the two control codes at the cursor before it moves.
                            if (s_data.char_code != CH_NEWLINE &&
                                s_data.char_code != CH_RETURN) begin
                                ram_wr_en = 1'b1;
                            end
                            col_next = put_col[COL_W-1:0];
                            if (put_row == ROWS_R) begin
                                row_next   = LAST_ROW;
                                state_next = ST_PRIME;
                            end else begin
                                row_next     = put_row[ROW_W-1:0];
                                m_valid_next = 1'b1;
                                m_data_next  = '{cell_data: 16'h0000,
                                                 cursor_row: 5'(put_row[ROW_W-1:0]),
                                                 cursor_col: 7'(put_col[COL_W-1:0])};
                            end
                        end
                        ACT_CLEAR: begin
                            row_next         = '0;
                            col_next         = '0;
                            sweep_next       = '0;
                            fill_data_next   = blank_cell;
                            fill_report_next = 1'b1;
                            state_next       = ST_FILL;
                        end
                        ACT_READ: begin
                            read_hit_next = 32'(s_data.cell_address) < CELL_COUNT;
                            ram_rd_en     = 32'(s_data.cell_address) < CELL_COUNT;
                            state_next    = ST_READ;
                        end
                        default: begin
                            // unused code: report the cursor, change nothing
                            m_valid_next = 1'b1;
                            m_data_next  = '{cell_data: 16'h0000,
                                             cursor_row: 5'(row_reg),
                                             cursor_col: 7'(col_reg)};
                        end
                    endcase
                end
            end
            ST_READ: begin
                m_valid_next = 1'b1;
                m_data_next  = '{cell_data: read_hit_reg ? ram_rd_data : 16'h0000,
                                 cursor_row: 5'(row_reg),
                                 cursor_col: 7'(col_reg)};
                state_next   = ST_IDLE;
            end
            ST_PRIME: begin
                ram_rd_en   = COLS_P < CELL_P;
                ram_rd_addr = ADDR_W'(COLS_P);
                sweep_next  = '0;
                state_next  = ST_SCROLL;
            end
            ST_SCROLL: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = sweep_reg;
                ram_wr_data = (PTR_W'(sweep_reg) < KEEP_P) ? ram_rd_data : blank_cell;
                ram_rd_en   = scroll_rd_ptr < CELL_P;
                ram_rd_addr = ADDR_W'(scroll_rd_ptr);
                if (sweep_reg == LAST_ADDR) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{cell_data: 16'h0000,
                                     cursor_row: 5'(row_reg),
                                     cursor_col: 7'(col_reg)};
                    state_next   = ST_IDLE;
                end else begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            ST_FILL: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = sweep_reg;
                ram_wr_data = fill_data_reg;
                if (sweep_reg == LAST_ADDR) begin
                    // the reset pass gives no result, a clear does
                    if (fill_report_reg) begin
                        m_valid_next = 1'b1;
                        m_data_next  = '{cell_data: 16'h0000,
                                         cursor_row: 5'(row_reg),
                                         cursor_col: 7'(col_reg)};
                    end
                    state_next = ST_IDLE;
                end else begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // Start with the zeroing pass over the whole store.
            state_reg       <= ST_FILL;
            sweep_reg       <= '0;
            fill_data_reg   <= '0;
            fill_report_reg <= 1'b0;
            read_hit_reg    <= 1'b0;
            row_reg         <= '0;
            col_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            sweep_reg       <= sweep_next;
            fill_data_reg   <= fill_data_next;
            fill_report_reg <= fill_report_next;
            read_hit_reg    <= read_hit_next;
            row_reg         <= row_next;
            col_reg         <= col_next;
            m_valid_reg     <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    // Configuration: foreground at 0x0, background at 0x4; low nibble kept.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_reg <= 4'hF;
            bg_reg <= 4'h0;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_FOREGROUND: fg_reg <= pwdata[3:0];
                REG_BACKGROUND: bg_reg <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_FOREGROUND: prdata = {28'h0, fg_reg};
            REG_BACKGROUND: prdata = {28'h0, bg_reg};
            default:        prdata = 32'h0;
        endcase
    end

endmodule

>>> rtl/tcw_checker.sv
// Port-level assertions for the text console writer, bound to the top level.
// Depends on tcw_pkg (payload types) and text_console_writer (bind target).
module tcw_checker #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25
) (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input tcw_pkg::req_t s_data,
    input logic          m_valid,
    input logic          m_ready,
    input tcw_pkg::rsp_t m_data
);

    import tcw_pkg::*;

    // Stalled result holds its payload.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Never take a transaction while an untaken result would be overwritten.
    a_one_outstanding: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> !m_valid || m_ready)
        else $error("transaction taken while result blocked");

    // The store is being zeroed right after reset: no traffic.
    a_init_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !s_ready && !m_valid)
        else $error("traffic during the zeroing pass");

    // Reported cursor stays on the screen.
    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((SCREEN_ROWS > 32) || (32'(m_data.cursor_row) < SCREEN_ROWS)) &&
                    ((SCREEN_COLUMNS > 128) || (32'(m_data.cursor_col) < SCREEN_COLUMNS)))
        else $error("cursor off screen");

endmodule

bind text_console_writer tcw_checker #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
) u_tcw_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

>>> tb/text_console_writer_test.sv
// Self-checking testbench for the text console writer (put, clear, read, scroll).
// Depends on tcw_pkg for payload types and codes, and on the text_console_writer RTL.
// Keeps its own screen model and checks every result against it.
module text_console_writer_test;
    import tcw_pkg::*;

    localparam int COLS = 80;
    localparam int ROWS = 25;
    localparam int CELLS = COLS * ROWS;
    localparam int ITEM_TARGET = 700;
    // Run the last stretch of random traffic with no gaps and no stalls
    localparam int QUIET_TAIL = 100;
    localparam int SCROLL_LINES = 28;
    // Slowest legal run: every transaction scrolling plus the worst sender gap
    // and receiver stall, plus the clearing pass after reset; then taken several
    // times over.
    localparam int CYCLE_LIMIT = 6_000_000;
    // Action code the block must ignore
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    req_t        s_data;
    logic        m_valid;
    logic        m_ready;
    rsp_t        m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Screen model: cells, cursor and attribute nibbles as the block should hold them
    logic [15:0] screen_model [CELLS];
    int          cur_row;
    int          cur_col;
    logic [3:0]  fg_color;
    logic [3:0]  bg_color;

    // Results predicted for accepted transactions, oldest first
    rsp_t        pending_results [$];
    rsp_t        oldest_result;

    int          items_sent;
    int          fail_count;
    int          cycle_count;
    bit          idle_on;
    bit          stall_on;

    text_console_writer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Guard against a hung block: any run this long has stopped making progress
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** text_console_writer: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Screen model
    // ------------------------------------------------------------------

    // Cell word: character in the low byte, {background, foreground} above it
    function automatic logic [15:0] make_cell(logic [7:0] ch);
        return {bg_color, fg_color, ch};
    endfunction

    // Apply one transaction to the screen model and return the result it must give
    function automatic rsp_t apply_console_item(req_t r);
        rsp_t        res;
        logic [15:0] blank;
        int          i;
        res = '0;
        blank = make_cell(CH_SPACE);
        case (r.action)
            ACT_PUT: begin
                if (r.char_code == CH_NEWLINE) begin
                    cur_col = 0;
                    cur_row++;
                end else if (r.char_code == CH_RETURN) begin
                    cur_col = 0;
                end else begin
                    screen_model[cur_row * COLS + cur_col] = make_cell(r.char_code);
                    cur_col++;
                    if (cur_col >= COLS) begin
                        cur_col = 0;
                        cur_row++;
                    end
                end
                // Past the last row: shift every row up, blank the bottom one
                if (cur_row >= ROWS) begin
                    for (i = COLS; i < CELLS; i++)
                        screen_model[i - COLS] = screen_model[i];
                    for (i = CELLS - COLS; i < CELLS; i++)
                        screen_model[i] = blank;
                    cur_row = ROWS - 1;
                end
            end
            ACT_CLEAR: begin
                for (i = 0; i < CELLS; i++)
                    screen_model[i] = blank;
                cur_row = 0;
                cur_col = 0;
            end
            ACT_READ: begin
                // Addresses past the store read as zero
                if (r.cell_address < CELLS)
                    res.cell_data = screen_model[r.cell_address];
            end
            default: begin
            end
        endcase
        res.cursor_row = 5'(cur_row);
        res.cursor_col = 7'(cur_col);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly printable text, now and then any byte but the two control codes
    function automatic logic [7:0] text_char();
        logic [7:0] c;
        if ($urandom_range(0, 9) == 0)
            c = 8'($urandom_range(0, 255));
        else
            c = 8'($urandom_range(33, 126));
        if (c == CH_NEWLINE || c == CH_RETURN)
            c = CH_SPACE;
        return c;
    endfunction

    // A cell on the cursor row or the one above it, where recent text lands
    function automatic logic [10:0] near_cursor_addr();
        int r;
        r = cur_row - int'($urandom_range(0, 1));
        if (r < 0)
            r = 0;
        return 11'(r * COLS + int'($urandom_range(0, COLS - 1)));
    endfunction

    // Mix of nearby cells, anywhere on screen, and addresses past the store
    function automatic logic [10:0] any_read_addr();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return near_cursor_addr();
        else if (sel < 9)
            return 11'($urandom_range(0, CELLS - 1));
        else
            return 11'($urandom_range(CELLS, 2047));
    endfunction

    // Send one transaction; called and returns at a falling edge, with
    // s_valid left high so back-to-back transactions need no drop
    task automatic send_item(input logic [1:0] act, input logic [7:0] ch,
                             input logic [10:0] addr);
        req_t r;
        r.action = act;
        r.char_code = ch;
        r.cell_address = addr;
        // Insert an idle burst now and then
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data = r;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(apply_console_item(r));
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic put_char(input logic [7:0] ch);
        send_item(ACT_PUT, ch, 11'($urandom_range(0, 2047)));
    endtask

    task automatic read_cell(input logic [10:0] addr);
        send_item(ACT_READ, 8'($urandom_range(0, 255)), addr);
    endtask

    // Hold the sender until every expected result is in and the block is ready
    task automatic wait_drain();
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        while (!s_ready) @(negedge aclk);
    endtask

    // One APB write: setup phase, then access phase until pready
    task automatic cfg_write(input logic idx, input logic [3:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        // Upper data bits are junk the register must drop
        pwdata = ($urandom() & 32'hFFFF_FFF0) | 32'(value);
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == REG_FOREGROUND)
            fg_color = value;
        else
            bg_color = value;
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Change colors only with the block idle
    task automatic set_colors(input logic [3:0] fg, input logic [3:0] bg);
        wait_drain();
        cfg_write(REG_FOREGROUND, fg);
        cfg_write(REG_BACKGROUND, bg);
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic void note_failure(string what, int unsigned want, int unsigned got);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    endfunction

    // Compare every result transaction with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                note_failure("unexpected result", 32'd0, 32'(m_data));
            end else begin
                oldest_result = pending_results.pop_front();
                if (m_data.cell_data !== oldest_result.cell_data)
                    note_failure("cell_data", 32'(oldest_result.cell_data),
                                 32'(m_data.cell_data));
                if (m_data.cursor_row !== oldest_result.cursor_row)
                    note_failure("cursor_row", 32'(oldest_result.cursor_row),
                                 32'(m_data.cursor_row));
                if (m_data.cursor_col !== oldest_result.cursor_col)
                    note_failure("cursor_col", 32'(oldest_result.cursor_col),
                                 32'(m_data.cursor_col));
            end
        end
    end

    // Receiver: stall in random bursts while stalls are enabled
    initial begin
        m_ready = 1'b1;
        forever begin
            @(negedge aclk);
            if (stall_on && $urandom_range(0, 7) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge aclk);
            end
            m_ready = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // The store comes out of reset zeroed; reads past the end give zero;
    // the unused action changes nothing
    task automatic test_reset_contents();
        read_cell(11'd0);
        read_cell(11'(CELLS - 1));
        read_cell(11'(CELLS));
        read_cell(11'h7FF);
        send_item(ACT_UNUSED, 8'hFF, 11'h7FF);
    endtask

    // Extreme character bytes, both control codes, clear and the unused action
    task automatic test_put_and_controls();
        set_colors(4'h0, 4'hF);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(CH_SPACE);
        put_char(CH_RETURN);
        put_char(8'h41);
        put_char(CH_NEWLINE);
        put_char(CH_NEWLINE);
        put_char(8'h7E);
        read_cell(11'd0);
        read_cell(11'd1);
        read_cell(11'd2);
        read_cell(11'(2 * COLS));
        send_item(ACT_UNUSED, 8'h00, 11'd0);
        set_colors(4'hF, 4'hF);
        send_item(ACT_CLEAR, 8'h00, 11'h000);
        read_cell(11'd0);
        read_cell(11'(CELLS - 1));
    endtask

    // Lines of random text walk the cursor off the bottom; the first long
    // line wraps mid-screen, the last one wraps on the bottom row and scrolls
    task automatic test_scroll_lines();
        int row_idx;
        int len;
        set_colors(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        send_item(ACT_CLEAR, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
        for (row_idx = 0; row_idx < SCROLL_LINES; row_idx++) begin
            if (row_idx == 2)
                len = $urandom_range(COLS, COLS + 5);
            else
                len = $urandom_range(0, 3);
            repeat (len) put_char(text_char());
            if ($urandom_range(0, 5) == 0)
                put_char(CH_RETURN);
            put_char(CH_NEWLINE);
            if ($urandom_range(0, 2) == 0)
                read_cell(near_cursor_addr());
        end
        repeat ($urandom_range(COLS, COLS + 5)) put_char(text_char());
        // Check what scrolled into the bottom rows
        repeat (8) read_cell(11'((ROWS - 3) * COLS + int'($urandom_range(0, 3 * COLS - 1))));
    endtask

    // Extreme color pairs and one random pair; each change waits until the block is idle
    task automatic test_colors();
        logic [3:0] fg_list [4];
        logic [3:0] bg_list [4];
        int k;
        fg_list = '{4'h0, 4'hF, 4'hF, 4'($urandom_range(0, 15))};
        bg_list = '{4'h0, 4'h0, 4'hF, 4'($urandom_range(0, 15))};
        for (k = 0; k < 4; k++) begin
            set_colors(fg_list[k], bg_list[k]);
            put_char(text_char());
            put_char(text_char());
            read_cell(near_cursor_addr());
        end
        // Blanks take the current attribute
        send_item(ACT_CLEAR, 8'hFF, 11'h7FF);
        read_cell(11'($urandom_range(0, CELLS - 1)));
    endtask

    // Random mix up to the item target; the tail runs with no idling
    task automatic test_random_mix();
        int pick;
        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= ITEM_TARGET - QUIET_TAIL) begin
                idle_on = 1'b0;
                stall_on = 1'b0;
            end else if ($urandom_range(0, 149) == 0) begin
                set_colors(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
            end
            pick = $urandom_range(0, 99);
            if (pick < 30)
                put_char(8'($urandom_range(0, 255)));
            else if (pick < 55)
                put_char(text_char());
            else if (pick < 68)
                put_char(CH_NEWLINE);
            else if (pick < 71)
                put_char(CH_RETURN);
            else if (pick < 93)
                read_cell(any_read_addr());
            else if (pick < 94)
                send_item(ACT_CLEAR, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
            else
                send_item(ACT_UNUSED, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int i;
        // Drive every input to a known value before the first edge
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        items_sent = 0;
        fail_count = 0;
        idle_on = 1'b1;
        stall_on = 1'b1;
        // Model state after reset: zeroed store, cursor home, white on black
        for (i = 0; i < CELLS; i++)
            screen_model[i] = '0;
        cur_row = 0;
        cur_col = 0;
        fg_color = 4'hF;
        bg_color = 4'h0;

        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        // The block clears its store first; send_item waits out that pass
        test_reset_contents();
        test_put_and_controls();
        test_scroll_lines();
        test_colors();
        test_random_mix();

        // Drain, then wait on to catch stray results
        wait_drain();
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("** text_console_writer: PASSED **");
        end else begin
            $display("** text_console_writer: FAILED **");
        end
        $finish;
    end

endmodule

>>> text_console_writer.f
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/text_console_writer.sv
rtl/tcw_checker.sv
tb/text_console_writer_test.sv
